@@ rtl/cwed_pkg.sv @@
package cwed_pkg;

  // Width of one character byte.
  localparam int SYM_W = 8;

  // Beat kinds carried on the input tuser.
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WORD  = 1'b1;

  // Wavefront marker and the dictionary byte that travel with it along the row.
  typedef struct packed {
    logic             token;
    logic [SYM_W-1:0] sym;
  } link_t;

endpackage

@@ rtl/cwed_cell.sv @@
module cwed_cell #(
  parameter int CW  = 5,
  parameter int POS = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cwed_pkg::link_t               link_in,
  input  logic [CW-1:0]                 new_in,
  input  logic [CW-1:0]                 old_in,
  input  logic                          clear,
  input  logic                          q_we,
  input  logic [cwed_pkg::SYM_W-1:0]    q_sym,
  output cwed_pkg::link_t               link_out,
  output logic [CW-1:0]                 val,
  output logic [CW-1:0]                 old
);

  logic [cwed_pkg::SYM_W-1:0] qc;
  logic                       tok;
  logic [cwed_pkg::SYM_W-1:0] sym;
  logic [CW:0]                up_cost;
  logic [CW:0]                left_cost;
  logic [CW:0]                diag_cost;
  logic [CW:0]                min_a;
  logic [CW-1:0]              val_next;

  // Cost of delete, insert and substitute, and the smallest of the three.
  always_comb begin
    up_cost   = {1'b0, val} + (CW+1)'(1);
    left_cost = {1'b0, new_in} + (CW+1)'(1);
    diag_cost = {1'b0, old_in} + (CW+1)'(qc != link_in.sym);
    min_a     = (left_cost < up_cost) ? left_cost : up_cost;
    val_next  = (diag_cost < min_a) ? diag_cost[CW-1:0] : min_a[CW-1:0];
  end

  // Column entry and wavefront marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
      val <= CW'(POS);
    end else begin
      tok <= link_in.token;
      if (clear) begin
        val <= CW'(POS);
      end else if (link_in.token) begin
        val <= val_next;
      end
    end
  end

  // Entry before the update is the diagonal term for the next cell.
  always_ff @(posedge clk) begin
    if (link_in.token) begin
      sym <= link_in.sym;
      old <= val;
    end
    if (q_we) begin
      qc <= q_sym;
    end
  end

  assign link_out = '{token: tok, sym: sym};

endmodule

@@ rtl/closest_word_edit_distance.sv @@
// Channel  Dir  Beat contents
// s_*      in   tuser = action, tdata[7:0] = symbol, tlast = word_end
// m_*      out  tdata = word_number, best_number, best_distance, have_best,
//               exact_found (one beat per dictionary word end)
//
// A query byte is stored in its cell and the input stays ready. A dictionary
// byte is accepted, enters the head cell, and the wavefront then walks the
// MAX_LEN cells of the row; no new byte is taken until it is through. A word
// end adds the compare. Synchronous reset clears all control state and sets
// cell i of the column to i. A stalled result waits in the output register
// while the next byte is already taken; a second word end then waits for it.
module closest_word_edit_distance #(
  parameter int MAX_LEN    = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tuser,   // [0] action
  input  logic        s_tlast,   // word_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [15:0] word_number, [31:16] best_number,
                                 // [36:32] best_distance, [37] have_best,
                                 // [38] exact_found, [39] zero
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = $clog2(MAX_LEN + 2);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [LW-1:0]          qlen;
  logic                   loading;
  logic [LW-1:0]          wl;
  logic [CW-1:0]          val0;
  logic [CW-1:0]          old0;
  logic                   start_tok;
  logic [7:0]             start_sym;
  logic                   last_q;
  logic [INDEX_BITS-1:0]  wcnt;
  logic [INDEX_BITS-1:0]  best_idx;
  logic [CW-1:0]          best_score;
  logic                   best_valid;
  logic                   stopped;
  logic                   clear;

  logic                   accept;
  logic                   is_query;
  logic [LW-1:0]          qidx;
  logic                   q_wr;
  logic                   upd;
  logic                   finish_go;
  logic                   compare;
  logic [CW-1:0]          word_cost;
  logic                   take;
  logic [4:0]             dist_sat;

  cwed_pkg::link_t        links [0:MAX_LEN];
  logic [CW-1:0]          cval  [0:MAX_LEN];
  logic [CW-1:0]          cold  [0:MAX_LEN];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_query = (s_tuser == cwed_pkg::ACT_QUERY);
  assign qidx     = loading ? qlen : '0;
  assign q_wr     = accept && is_query && (qidx < LW'(MAX_LEN));
  assign upd      = (qlen <= LW'(MAX_LEN)) && (wl < LW'(MAX_LEN));

  // Head of the row: cell zero lives here.
  assign links[0] = '{token: start_tok, sym: start_sym};
  assign cval[0]  = val0;
  assign cold[0]  = old0;

  // Row of DP cells, one per query character.
  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    cwed_cell #(
      .CW  (CW),
      .POS (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (links[k-1]),
      .new_in   (cval[k-1]),
      .old_in   (cold[k-1]),
      .clear    (clear),
      .q_we     (q_wr && (qidx == LW'(k - 1))),
      .q_sym    (s_tdata),
      .link_out (links[k]),
      .val      (cval[k]),
      .old      (cold[k])
    );
  end

  // Word end compare against the best so far.
  assign finish_go = (state == ST_FINISH) && (!m_tvalid || m_tready);
  assign compare   = !stopped && (wl == qlen) && (wl <= LW'(MAX_LEN));
  assign word_cost = cval[qlen[CW-1:0]];
  assign take      = compare && (!best_valid || word_cost <= best_score);
  assign clear     = finish_go || (accept && is_query && !loading);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !is_query) begin
          if (upd) begin
            state_next = ST_SWEEP;
          end else if (s_tlast) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        if (links[MAX_LEN].token) begin
          state_next = last_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control and search record.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      qlen       <= '0;
      loading    <= 1'b0;
      wl         <= '0;
      val0       <= '0;
      start_tok  <= 1'b0;
      wcnt       <= '0;
      best_idx   <= '0;
      best_score <= '0;
      best_valid <= 1'b0;
      stopped    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state     <= state_next;
      start_tok <= accept && !is_query && upd;
      if (finish_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept && is_query) begin
        if (!loading) begin
          val0       <= '0;
          wl         <= '0;
          wcnt       <= '0;
          best_idx   <= '0;
          best_score <= '0;
          best_valid <= 1'b0;
          stopped    <= 1'b0;
        end
        if (qidx <= LW'(MAX_LEN)) begin
          qlen <= qidx + LW'(1);
        end else begin
          qlen <= qidx;
        end
        loading <= !s_tlast;
      end else if (accept) begin
        loading <= 1'b0;
        if (upd) begin
          val0 <= CW'(wl + LW'(1));
        end
        if (wl <= LW'(MAX_LEN)) begin
          wl <= wl + LW'(1);
        end
      end
      if (finish_go) begin
        if (wcnt != '1) begin
          wcnt <= wcnt + INDEX_BITS'(1);
        end
        if (take) begin
          best_valid <= 1'b1;
          best_score <= word_cost;
          best_idx   <= wcnt;
        end
        if (compare && word_cost == '0) begin
          stopped <= 1'b1;
        end
        val0 <= '0;
        wl   <= '0;
      end
    end
  end

  // Payload registers.
  always_comb begin
    if (int'(take ? word_cost : best_score) > 31) begin
      dist_sat = 5'd31;
    end else begin
      dist_sat = 5'(take ? word_cost : best_score);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_query) begin
      old0      <= val0;
      start_sym <= s_tdata;
      last_q    <= s_tlast;
    end
    if (finish_go) begin
      m_tdata[15:0]  <= 16'(wcnt);
      m_tdata[31:16] <= take ? 16'(wcnt) : 16'(best_idx);
      m_tdata[36:32] <= dist_sat;
      m_tdata[37]    <= take || best_valid;
      m_tdata[38]    <= stopped || (compare && word_cost == '0);
      m_tdata[39]    <= 1'b0;
    end
  end

endmodule
